@@ rtl/cppb_pkg.sv @@
// ----------------------------------------------------------------------------
// cppb_pkg
// shared types for the can ping-pong buffer: stored message layout and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cppb_pkg;

    localparam int unsigned ID_W      = 29;
    localparam int unsigned LENGTH_W  = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned FILTER_W  = 8;

    // one stored message, id in the lowest bits
    typedef struct packed {
        logic [FILTER_W-1:0]  filter_index;
        logic [PAYLOAD_W-1:0] payload;
        logic [LENGTH_W-1:0]  length;
        logic                 remote;
        logic                 ext_format;
        logic [ID_W-1:0]      id;
    } msg_t;

    localparam int unsigned MSG_W = $bits(msg_t);

    // buffer select codes
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic push;      // append the incoming item
        logic push_sel;  // buffer to append to
        logic pop;       // remove the oldest entry and start its read
        logic pop_sel;   // buffer to remove from
        logic load_out;  // move the read data into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic a_empty;
        logic a_full;
        logic b_empty;
        logic b_full;
        logic out_free;  // output register can take a new item this cycle
    } status_t;

endpackage : cppb_pkg

`default_nettype wire

@@ rtl/cppb_ram.sv @@
// ----------------------------------------------------------------------------
// cppb_ram
// generic simple dual-port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cppb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : cppb_ram

`default_nettype wire

@@ rtl/cppb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cppb_ctrl
// sequencer plus the fill and drain state machines of the ping-pong buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cppb_ctrl
    import cppb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SEND,
        SEQ_READ
    } seq_t;

    typedef enum logic [1:0] {
        FILL_A,
        FILL_B,
        FILL_WAIT
    } fill_t;

    typedef enum logic [1:0] {
        DRAIN_IDLE,
        DRAIN_A,
        DRAIN_B
    } drain_t;

    seq_t   seq_reg,   seq_next;
    fill_t  fill_reg,  fill_next;
    drain_t drain_reg, drain_next;
    logic   accept;

    assign in_ready = (seq_reg == SEQ_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        seq_next   = seq_reg;
        fill_next  = fill_reg;
        drain_next = drain_reg;
        cmd        = '0;

        unique case (seq_reg)
            SEQ_IDLE:
            begin
                // save step on the accept edge
                if (accept)
                begin
                    seq_next = SEQ_SEND;
                    unique case (fill_reg)
                        FILL_A:
                        begin
                            if (!status.a_full)
                            begin
                                cmd.push     = 1'b1;
                                cmd.push_sel = SEL_A;
                            end
                            else
                            begin
                                fill_next = status.b_empty ? FILL_B : FILL_WAIT;
                            end
                        end
                        FILL_B:
                        begin
                            if (!status.b_full)
                            begin
                                cmd.push     = 1'b1;
                                cmd.push_sel = SEL_B;
                            end
                            else
                            begin
                                fill_next = status.a_empty ? FILL_A : FILL_WAIT;
                            end
                        end
                        default:
                        begin
                            if (status.a_empty)
                            begin
                                fill_next = FILL_A;
                            end
                            else if (status.b_empty)
                            begin
                                fill_next = FILL_B;
                            end
                            else
                            begin
                                fill_next = FILL_WAIT;
                            end
                        end
                    endcase
                end
            end
            SEQ_SEND:
            begin
                // send step sees the counts as the save step left them
                seq_next = SEQ_IDLE;
                unique case (drain_reg)
                    DRAIN_A:
                    begin
                        if (status.a_empty)
                        begin
                            drain_next = DRAIN_IDLE;
                        end
                        else
                        begin
                            cmd.pop     = 1'b1;
                            cmd.pop_sel = SEL_A;
                            seq_next    = SEQ_READ;
                        end
                    end
                    DRAIN_B:
                    begin
                        if (status.b_empty)
                        begin
                            drain_next = DRAIN_IDLE;
                        end
                        else
                        begin
                            cmd.pop     = 1'b1;
                            cmd.pop_sel = SEL_B;
                            seq_next    = SEQ_READ;
                        end
                    end
                    default:
                    begin
                        if (status.a_full)
                        begin
                            drain_next = DRAIN_A;
                        end
                        else if (status.b_full)
                        begin
                            drain_next = DRAIN_B;
                        end
                        else
                        begin
                            drain_next = DRAIN_IDLE;
                        end
                    end
                endcase
            end
            SEQ_READ:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    seq_next     = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_IDLE;
            fill_reg  <= FILL_A;
            drain_reg <= DRAIN_IDLE;
        end
        else
        begin
            seq_reg   <= seq_next;
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
        end
    end

endmodule : cppb_ctrl

`default_nettype wire

@@ rtl/cppb_datapath.sv @@
// ----------------------------------------------------------------------------
// cppb_datapath
// head and fill counters of both buffers, the message ram and the output
// register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cppb_datapath
    import cppb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 10
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    output status_t      status,
    input  wire msg_t    in_msg,
    output msg_t         out_msg,
    output logic         out_source,
    output logic         out_valid,
    input  wire logic    out_ready
);

    localparam int unsigned RAM_DEPTH = 2 * QUEUE_DEPTH;
    localparam int unsigned AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int unsigned HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] QD_A    = AW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] QD_C    = CW'(QUEUE_DEPTH);
    localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

    logic [HW-1:0] head_a_reg, head_a_next, head_b_reg, head_b_next;
    logic [CW-1:0] count_a_reg, count_a_next, count_b_reg, count_b_next;

    logic [HW-1:0] push_head, pop_head;
    logic [CW-1:0] push_count;
    logic [AW-1:0] wsum, wslot, waddr, raddr;
    msg_t          rdata;

    logic          src_reg;
    logic          out_valid_reg, out_valid_next;
    msg_t          out_msg_reg;
    logic          out_source_reg;

    // write slot: (head + count) mod depth, sum stays below twice the depth
    assign push_head  = cmd.push_sel ? head_b_reg  : head_a_reg;
    assign push_count = cmd.push_sel ? count_b_reg : count_a_reg;
    assign wsum  = AW'(push_head) + AW'(push_count);
    assign wslot = (wsum >= QD_A) ? (wsum - QD_A) : wsum;
    assign waddr = wslot + (cmd.push_sel ? QD_A : '0);

    assign pop_head = cmd.pop_sel ? head_b_reg : head_a_reg;
    assign raddr    = AW'(pop_head) + (cmd.pop_sel ? QD_A : '0);

    always_comb
    begin
        head_a_next  = head_a_reg;
        head_b_next  = head_b_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (cmd.push)
        begin
            if (cmd.push_sel == SEL_B)
            begin
                count_b_next = count_b_reg + CW'(1);
            end
            else
            begin
                count_a_next = count_a_reg + CW'(1);
            end
        end
        else if (cmd.pop)
        begin
            if (cmd.pop_sel == SEL_B)
            begin
                count_b_next = count_b_reg - CW'(1);
                head_b_next  = (head_b_reg == HEAD_LAST) ? '0 : head_b_reg + HW'(1);
            end
            else
            begin
                count_a_next = count_a_reg - CW'(1);
                head_a_next  = (head_a_reg == HEAD_LAST) ? '0 : head_a_reg + HW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_a_reg  <= '0;
            head_b_reg  <= '0;
            count_a_reg <= '0;
            count_b_reg <= '0;
        end
        else
        begin
            head_a_reg  <= head_a_next;
            head_b_reg  <= head_b_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

    cppb_ram #(
        .WIDTH (MSG_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (waddr),
        .wdata (in_msg),
        .re    (cmd.pop),
        .raddr (raddr),
        .rdata (rdata)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            src_reg <= cmd.pop_sel;
        end
        if (cmd.load_out)
        begin
            out_msg_reg    <= rdata;
            out_source_reg <= src_reg;
        end
    end

    assign status.a_empty  = (count_a_reg == '0);
    assign status.a_full   = (count_a_reg >= QD_C);
    assign status.b_empty  = (count_b_reg == '0);
    assign status.b_full   = (count_b_reg >= QD_C);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_msg    = out_msg_reg;
    assign out_source = out_source_reg;
    assign out_valid  = out_valid_reg;

endmodule : cppb_datapath

`default_nettype wire

@@ rtl/can_ping_pong_buffer_core.sv @@
// ----------------------------------------------------------------------------
// can_ping_pong_buffer_core
// ping-pong double buffer for received can messages
// ----------------------------------------------------------------------------
// Each item on the input stream is one received can message. Two buffers, A
// and B, of QUEUE_DEPTH entries each share one ram of 2*QUEUE_DEPTH words.
// A fill machine appends items to one buffer at a time; when that buffer is
// full the item is dropped and filling moves to the other buffer if it is
// empty, or waits until one of them is. A drain machine starts on a full
// buffer and forwards one of its entries, oldest first, per input item, so
// at most one result leaves for each item taken in. An item that causes no
// result passes through the accept and drain decision steps; one that
// forwards a message also has a ram read and a load of the output register,
// which waits while m_axis_tready blocks the output register. The separate
// read and load steps come from the single ram read port and its registered
// read. A finished result sits in the output register while the next item
// is accepted. The ram needs no clearing after reset: only entries that
// hold a message are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module can_ping_pong_buffer_core
    import cppb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 10
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // input stream, one received message per item
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: in_id [28:0], in_length [32:29], in_payload [96:33],
    //        in_filter_index [104:97], zero fill [111:105]
    input  wire logic [111:0] s_axis_tdata,
    // tuser: in_ext_format [0], in_remote [1]
    input  wire logic [1:0]   s_axis_tuser,

    // output stream, one forwarded message per item
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: out_id [28:0], out_length [32:29], out_payload [96:33],
    //        out_filter_index [104:97], zero fill [111:105]
    output logic [111:0]      m_axis_tdata,
    // tuser: out_ext_format [0], out_remote [1], source_buffer [2]
    output logic [2:0]        m_axis_tuser
);

    cmd_t    cmd;
    status_t status;
    msg_t    in_msg;
    msg_t    out_msg;
    logic    out_source;

    // unpack the incoming item into the stored message layout
    always_comb
    begin
        in_msg.id           = s_axis_tdata[28:0];
        in_msg.length       = s_axis_tdata[32:29];
        in_msg.payload      = s_axis_tdata[96:33];
        in_msg.filter_index = s_axis_tdata[104:97];
        in_msg.ext_format   = s_axis_tuser[0];
        in_msg.remote       = s_axis_tuser[1];
    end

    // sequencer, fill and drain machines
    cppb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, message ram and output register
    cppb_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_msg     (in_msg),
        .out_msg    (out_msg),
        .out_source (out_source),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    // pack the forwarded item
    assign m_axis_tdata = {7'd0, out_msg.filter_index, out_msg.payload,
                           out_msg.length, out_msg.id};
    assign m_axis_tuser = {out_source, out_msg.remote, out_msg.ext_format};

endmodule : can_ping_pong_buffer_core

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the can ping-pong double buffer
// ----------------------------------------------------------------------------
// A queue of pending messages feeds a stream driver; each accepted message
// runs through an in-bench copy of the fill and drain machines, which holds
// both buffers as queues and predicts the forwarded message, if any. A
// monitor checks every forwarded item against the oldest prediction. Both
// stream sides idle at random, with calm stretches that have no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import cppb_pkg::*;
();

    localparam int unsigned DEPTH       = 10;
    localparam int unsigned DIRECTED_N  = 24;
    localparam int unsigned RANDOM_N    = 1550;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned REPORT_MAX  = 10;

    // fill and drain machine states of the prediction
    typedef enum logic [1:0] {FILL_A, FILL_B, FILL_WAIT} fill_e;
    typedef enum logic [1:0] {DRAIN_IDLE, DRAIN_A, DRAIN_B} drain_e;

    // one forwarded message and the buffer it came from
    typedef struct packed {
        msg_t msg;
        logic src;
    } fwd_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [111:0] s_data = '0;
    logic [1:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [111:0] m_data;
    logic [2:0]   m_user;

    msg_t        pending_msgs[$];
    msg_t        ping_buf[$];
    msg_t        pong_buf[$];
    fwd_t        forward_due[$];
    fill_e       fill_st = FILL_A;
    drain_e      drain_st = DRAIN_IDLE;
    msg_t        on_bus;
    int unsigned src_gap = 0;
    int unsigned sink_stall = 0;
    int unsigned cycle_cnt = 0;
    int unsigned error_cnt = 0;

    can_ping_pong_buffer_core #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle length: mostly short, a few long, none in calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if ((cycle_cnt % 1024) < 256)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic msg_t random_msg();
        msg_t m;
        m.ext_format   = 1'($urandom_range(1));
        m.remote       = ($urandom_range(4) == 0);
        // identifier usually matches its format, sometimes any value
        if (!m.ext_format && $urandom_range(4) != 0)
            m.id = {18'd0, 11'($urandom)};
        else
            m.id = 29'($urandom);
        m.length       = ($urandom_range(6) == 0) ? 4'($urandom) : 4'($urandom_range(8));
        m.payload      = {$urandom, $urandom};
        m.filter_index = 8'($urandom);
        return m;
    endfunction

    // save step then send step, the send step seeing the buffers as just left
    task automatic advance_buffers(input msg_t m);
        fwd_t f;
        case (fill_st)
            FILL_A:
            begin
                if (ping_buf.size() < DEPTH)
                    ping_buf.push_back(m);
                else
                    fill_st = (pong_buf.size() == 0) ? FILL_B : FILL_WAIT;
            end
            FILL_B:
            begin
                if (pong_buf.size() < DEPTH)
                    pong_buf.push_back(m);
                else
                    fill_st = (ping_buf.size() == 0) ? FILL_A : FILL_WAIT;
            end
            default:
            begin
                // message dropped in the wait state, which is left for an empty buffer
                if (ping_buf.size() == 0)
                    fill_st = FILL_A;
                else if (pong_buf.size() == 0)
                    fill_st = FILL_B;
                else
                    fill_st = FILL_WAIT;
            end
        endcase
        case (drain_st)
            DRAIN_A:
            begin
                if (ping_buf.size() == 0)
                    drain_st = DRAIN_IDLE;
                else
                begin
                    f.msg = ping_buf.pop_front();
                    f.src = SEL_A;
                    forward_due.push_back(f);
                end
            end
            DRAIN_B:
            begin
                if (pong_buf.size() == 0)
                    drain_st = DRAIN_IDLE;
                else
                begin
                    f.msg = pong_buf.pop_front();
                    f.src = SEL_B;
                    forward_due.push_back(f);
                end
            end
            default:
            begin
                if (ping_buf.size() >= DEPTH)
                    drain_st = DRAIN_A;
                else if (pong_buf.size() >= DEPTH)
                    drain_st = DRAIN_B;
                else
                    drain_st = DRAIN_IDLE;
            end
        endcase
    endtask

    // input driver: predict on acceptance, then present the next item or idle
    always @(posedge clk)
    begin
        logic nv;
        nv = s_valid;
        if (rst_n)
        begin
            if (s_valid && s_ready)
            begin
                advance_buffers(on_bus);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_msgs.size() > 0)
                begin
                    on_bus = pending_msgs.pop_front();
                    s_data <= {7'd0, on_bus.filter_index, on_bus.payload,
                               on_bus.length, on_bus.id};
                    s_user <= {on_bus.remote, on_bus.ext_format};
                    nv = 1'b1;
                    src_gap = pick_gap();
                end
            end
            s_valid <= nv;
        end
    end

    // output monitor with random backpressure
    always @(posedge clk)
    begin
        fwd_t exp_f;
        fwd_t got_f;
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                got_f.msg.id           = m_data[28:0];
                got_f.msg.length       = m_data[32:29];
                got_f.msg.payload      = m_data[96:33];
                got_f.msg.filter_index = m_data[104:97];
                got_f.msg.ext_format   = m_user[0];
                got_f.msg.remote       = m_user[1];
                got_f.src              = m_user[2];
                if (forward_due.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= REPORT_MAX)
                        $display("unexpected item: id %h len %h payload %h filt %h src %b",
                                 got_f.msg.id, got_f.msg.length, got_f.msg.payload,
                                 got_f.msg.filter_index, got_f.src);
                end
                else
                begin
                    exp_f = forward_due.pop_front();
                    if (got_f !== exp_f)
                    begin
                        error_cnt++;
                        if (error_cnt <= REPORT_MAX)
                        begin
                            $display("mismatch exp: id %h ext %b rtr %b len %h ",
                                     exp_f.msg.id, exp_f.msg.ext_format,
                                     exp_f.msg.remote, exp_f.msg.length,
                                     "payload %h filt %h src %b",
                                     exp_f.msg.payload, exp_f.msg.filter_index,
                                     exp_f.src);
                            $display("         got: id %h ext %b rtr %b len %h ",
                                     got_f.msg.id, got_f.msg.ext_format,
                                     got_f.msg.remote, got_f.msg.length,
                                     "payload %h filt %h src %b",
                                     got_f.msg.payload, got_f.msg.filter_index,
                                     got_f.src);
                        end
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_ready <= 1'b0;
            end
            else
            begin
                m_ready <= 1'b1;
                sink_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("can_ping_pong_buffer_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        msg_t m;
        // directed: field extremes, all flag combinations, lengths above eight
        for (int k = 0; k < DIRECTED_N; k++)
        begin
            m.id           = (k % 3 == 0) ? 29'd0 : (k % 3 == 1) ? '1 : 29'h7ff;
            m.ext_format   = k[0];
            m.remote       = k[1];
            m.length       = (k < 16) ? 4'(k) : 4'd8;
            m.payload      = (k % 4 == 0) ? 64'd0 : (k % 4 == 1) ? '1
                           : 64'h0706050403020100 + 64'(k);
            m.filter_index = (k % 2 == 0) ? 8'h00 : 8'hff;
            pending_msgs.push_back(m);
        end
        for (int k = 0; k < RANDOM_N; k++)
            pending_msgs.push_back(random_msg());

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_msgs.size() > 0 || s_valid || forward_due.size() > 0)
            @(posedge clk);
        // anything still arriving now has no prediction
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_cnt == 0)
            $display("can_ping_pong_buffer_core regression: pass");
        else
            $display("can_ping_pong_buffer_core regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cppb_pkg.sv
rtl/cppb_ram.sv
rtl/cppb_ctrl.sv
rtl/cppb_datapath.sv
rtl/can_ping_pong_buffer_core.sv
bench/tb.sv
